// ===== rtl/core/wljq_pkg.sv =====
package wljq_pkg;
   localparam int NUM_LEVELS_DEF = 8;
   localparam int FIFO_DEPTH_DEF = 16;
   localparam int ID_W   = 32;
   localparam int KIND_W = 8;
   localparam int LVL_W  = 4;
   localparam int RND_W  = 16;
   localparam int ST_W   = 3;
   localparam int HELD_W = 8;

   typedef enum logic [ST_W-1:0] {
      ST_PUSHED = 3'd0,
      ST_POPPED = 3'd1,
      ST_EMPTY  = 3'd2,
      ST_FULL   = 3'd3,
      ST_BADLVL = 3'd4
   } status_type;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;
endpackage

// ===== rtl/core/wljq_ram.sv =====
module wljq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/core/weighted_lottery_job_queue.sv =====
// Weighted lottery job queue. Jobs (32-bit id, 8-bit kind) are kept in one
// FIFO per priority level 1..NUM_LEVELS, all sharing a single-port-write,
// registered-read job RAM. A push appends the job to its level. Its response
// beat is valid in the cycle after the request beat is accepted. A pop first
// sums the weights of the non-empty levels, one level per cycle. It then
// reduces the random draw modulo that sum with a restoring divider that
// settles one quotient bit per cycle. Next it walks the levels in ascending
// order, subtracting each active weight until the draw falls inside one.
// Finally it reads the head job from the registered-read RAM in the S_READ
// and S_WAIT states. A pop on an empty queue is answered straight after the
// weight sum. The block takes one beat at a time: req_tready is high only
// while idle, and each beat yields exactly one response beat, held in an
// output register until rsp_tready takes it. The next request can be
// accepted in the cycle after that handshake. Bad levels, full FIFOs and
// pops on an empty queue answer with an error status.
module weighted_lottery_job_queue #(
   parameter int NUM_LEVELS = wljq_pkg::NUM_LEVELS_DEF,
   parameter int FIFO_DEPTH = wljq_pkg::FIFO_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // job_id[31:0], job_kind[39:32], push_level[43:40], random_value[59:44],
   // zero fill [63:60]
   input  logic [63:0] req_tdata,
   // action
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // popped_id[31:0], popped_kind[39:32], popped_level[43:40],
   // jobs_held[51:44], zero fill [55:52]
   output logic [55:0] rsp_tdata,
   // status
   output logic [2:0]  rsp_tuser
);
   import wljq_pkg::*;

   localparam int LI_W   = $clog2(NUM_LEVELS);
   localparam int SL_W   = $clog2(FIFO_DEPTH);
   localparam int FL_W   = $clog2(FIFO_DEPTH + 1);
   localparam int ADDR_W = LI_W + SL_W;
   localparam int WGT_W  = $clog2(NUM_LEVELS * (NUM_LEVELS + 1) / 2 + 1);
   localparam int BIT_W  = $clog2(RND_W + 1);
   localparam int ENT_W  = ID_W + KIND_W;

   typedef enum logic [2:0] {
      S_IDLE, S_WSUM, S_DIV, S_SCAN, S_READ, S_WAIT, S_RESP
   } state_type;

   state_type                 state_ff, state_in;
   logic [SL_W-1:0]           head_ff [NUM_LEVELS];
   logic [SL_W-1:0]           tail_ff [NUM_LEVELS];
   logic [FL_W-1:0]           fill_ff [NUM_LEVELS];
   logic [HELD_W-1:0]         total_ff;
   logic [LI_W-1:0]           idx_ff, idx_in;
   logic [WGT_W-1:0]          wsum_ff, wsum_in;
   logic [WGT_W-1:0]          rem_ff, rem_in;
   logic [BIT_W-1:0]          bit_ff, bit_in;
   logic [RND_W-1:0]          draw_ff, draw_in;
   logic                      rsp_valid_ff;
   logic [ST_W-1:0]           rsp_st_ff;
   logic [ID_W-1:0]           rsp_id_ff;
   logic [KIND_W-1:0]         rsp_kind_ff;
   logic [LVL_W-1:0]          rsp_lvl_ff;

   logic                      accept;
   logic [LVL_W-1:0]          req_level;
   logic [LI_W-1:0]           req_li;
   logic                      wr_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic [ENT_W-1:0]          rd_data;
   logic [WGT_W-1:0]          idx_wgt;
   logic [WGT_W:0]            rem_shift;
   logic                      last_lvl;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_level  = req_tdata[43:40];
   assign req_li     = LI_W'(req_level - LVL_W'(1));
   assign idx_wgt    = WGT_W'(idx_ff) + WGT_W'(1);
   assign rem_shift  = {rem_ff, draw_ff[RND_W-1]};
   assign last_lvl   = (idx_ff == LI_W'(NUM_LEVELS - 1));
   assign wr_en      = accept && (req_tuser == ACT_PUSH) && (req_level != '0)
                       && (32'(req_level) <= NUM_LEVELS)
                       && (32'(fill_ff[req_li]) < FIFO_DEPTH);
   assign rd_addr    = {idx_ff, head_ff[idx_ff]};

   // Each level owns a slot range of 2**SL_W entries in the RAM.
   wljq_ram #(.WIDTH(ENT_W), .DEPTH(NUM_LEVELS * (2 ** SL_W))) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({req_li, tail_ff[req_li]}),
      .wr_data (req_tdata[ENT_W-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer next-state: weight sum, remainder, level walk.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      wsum_in  = wsum_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      draw_in  = draw_ff;
      case (state_ff)
         S_IDLE: begin
            idx_in  = '0;
            wsum_in = '0;
            rem_in  = '0;
            bit_in  = BIT_W'(RND_W);
            draw_in = req_tdata[59:44];
            if (accept) begin
               state_in = (req_tuser == ACT_POP) ? S_WSUM : S_RESP;
            end
         end
         S_WSUM: begin
            if (fill_ff[idx_ff] != '0) begin
               wsum_in = wsum_ff + idx_wgt;
            end
            idx_in = idx_ff + LI_W'(1);
            if (last_lvl) begin
               idx_in   = '0;
               // A zero total weight means the queue is empty.
               state_in = (wsum_in == '0) ? S_RESP : S_DIV;
            end
         end
         S_DIV: begin
            // Restoring remainder, one draw bit per cycle.
            if (rem_shift >= {1'b0, wsum_ff}) begin
               rem_in = WGT_W'(rem_shift - {1'b0, wsum_ff});
            end else begin
               rem_in = WGT_W'(rem_shift);
            end
            draw_in = {draw_ff[RND_W-2:0], 1'b0};
            bit_in  = bit_ff - BIT_W'(1);
            if (bit_ff == BIT_W'(1)) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (fill_ff[idx_ff] != '0 && rem_ff < idx_wgt) begin
               state_in = S_READ;
            end else begin
               if (fill_ff[idx_ff] != '0) begin
                  rem_in = rem_ff - idx_wgt;
               end
               idx_in = idx_ff + LI_W'(1);
            end
         end
         S_READ:  state_in = S_WAIT;
         S_WAIT:  state_in = S_RESP;
         S_RESP: begin
            if (rsp_valid_ff && rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            rsp_id_ff   <= '0;
            rsp_kind_ff <= '0;
            rsp_lvl_ff  <= '0;
            if (req_tuser == ACT_PUSH) begin
               rsp_valid_ff <= 1'b1;
               if (req_level == '0 || 32'(req_level) > NUM_LEVELS) begin
                  rsp_st_ff <= ST_BADLVL;
               end else if (!wr_en) begin
                  rsp_st_ff <= ST_FULL;
               end else begin
                  rsp_st_ff        <= ST_PUSHED;
                  tail_ff[req_li]  <= (tail_ff[req_li] == SL_W'(FIFO_DEPTH - 1))
                                      ? '0 : tail_ff[req_li] + SL_W'(1);
                  fill_ff[req_li]  <= fill_ff[req_li] + FL_W'(1);
                  total_ff         <= total_ff + HELD_W'(1);
               end
            end
         end
         if (state_ff == S_WSUM && last_lvl && wsum_in == '0) begin
            rsp_valid_ff <= 1'b1;
            rsp_st_ff    <= ST_EMPTY;
         end
         if (state_ff == S_READ) begin
            head_ff[idx_ff] <= (head_ff[idx_ff] == SL_W'(FIFO_DEPTH - 1))
                               ? '0 : head_ff[idx_ff] + SL_W'(1);
            fill_ff[idx_ff] <= fill_ff[idx_ff] - FL_W'(1);
            total_ff        <= total_ff - HELD_W'(1);
            rsp_lvl_ff      <= LVL_W'(idx_wgt);
         end
         if (state_ff == S_WAIT) begin
            // The RAM entry holds the id in its low bits, the kind above it.
            rsp_valid_ff <= 1'b1;
            rsp_st_ff    <= ST_POPPED;
            rsp_id_ff    <= rd_data[ID_W-1:0];
            rsp_kind_ff  <= rd_data[ENT_W-1:ID_W];
         end
      end
      idx_ff  <= idx_in;
      wsum_ff <= wsum_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
      draw_ff <= draw_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tdata  = {4'd0, total_ff, rsp_lvl_ff, rsp_kind_ff, rsp_id_ff};
endmodule

// ===== rtl/core/wljq_checker.sv =====
module wljq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import wljq_pkg::*;

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a response waits");

   a_push_answer: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ACT_PUSH |=> rsp_tvalid && !req_tready)
      else $error("push not answered in the next cycle");

   a_push_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_PUSHED || rsp_tuser == ST_FULL
                     || rsp_tuser == ST_BADLVL || rsp_tuser == ST_EMPTY)
      |-> rsp_tdata[43:0] == 44'd0)
      else $error("non-pop response carries job data");

   a_pop_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_POPPED |-> rsp_tdata[43:40] != 4'd0)
      else $error("pop response without a level");
endmodule

bind weighted_lottery_job_queue wljq_checker u_wljq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/wljq_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the job queue, keeps its own picture of the
// per-level FIFOs, and compares every response beat with the oldest
// outstanding prediction.
module wljq_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_count,
   output int          pop_hits,
   output int          error_hits
);
   import wljq_pkg::*;

   localparam int LEVELS = NUM_LEVELS_DEF;
   localparam int DEPTH  = FIFO_DEPTH_DEF;

   typedef struct packed {
      status_type           status;
      logic [ID_W-1:0]      id;
      logic [KIND_W-1:0]    kind;
      logic [LVL_W-1:0]     level;
      logic [HELD_W-1:0]    held;
   } answer_type;

   // Each level holds its jobs as {id, kind} in arrival order.
   logic [ID_W+KIND_W-1:0] level_jobs [LEVELS][$];
   answer_type             answers_due [$];
   logic [HELD_W-1:0]      held_count;

   function automatic answer_type schedule_job(logic act, logic [63:0] d);
      answer_type          a;
      logic [LVL_W-1:0]    lvl;
      logic [RND_W-1:0]    draw;
      int                  weight;
      int                  r;
      logic [ID_W+KIND_W-1:0] job;
      a = '{status: ST_EMPTY, default: '0};
      lvl  = d[43:40];
      draw = d[59:44];
      if (act == ACT_PUSH) begin
         if (lvl == 0 || lvl > LEVELS) begin
            a.status = ST_BADLVL;
         end else if (level_jobs[lvl-1].size() >= DEPTH) begin
            a.status = ST_FULL;
         end else begin
            job = {d[31:0], d[39:32]};
            level_jobs[lvl-1] = {level_jobs[lvl-1], job};
            held_count++;
            a.status = ST_PUSHED;
         end
      end else begin
         weight = 0;
         for (int i = 0; i < LEVELS; i++)
            if (level_jobs[i].size() != 0) weight += i + 1;
         if (weight != 0) begin
            r = int'(draw) % weight;
            for (int i = 0; i < LEVELS; i++) begin
               if (level_jobs[i].size() != 0) begin
                  if (r < i + 1) begin
                     job = level_jobs[i].pop_front();
                     held_count--;
                     a.status = ST_POPPED;
                     a.id     = job[ID_W+KIND_W-1:KIND_W];
                     a.kind   = job[KIND_W-1:0];
                     a.level  = LVL_W'(i + 1);
                     break;
                  end
                  r -= i + 1;
               end
            end
         end
      end
      a.held = held_count;
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      answer_type got;
      answer_type due;
      if (reset) begin
         answers_due.delete();
         for (int i = 0; i < LEVELS; i++) level_jobs[i].delete();
         held_count = '0;
         fail_count <= 0;
         pop_hits   <= 0;
         error_hits <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            due = schedule_job(req_tuser, req_tdata);
            answers_due = {answers_due, due};
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{status: status_type'(rsp_tuser), id: rsp_tdata[31:0],
                    kind: rsp_tdata[39:32], level: rsp_tdata[43:40],
                    held: rsp_tdata[51:44]};
            if (answers_due.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response beat: status %0d id %h",
                           got.status, got.id);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (got !== want || rsp_tdata[55:52] !== 4'd0) begin
                  if (fail_count < 10)
                     $display({"mismatch: expected st %0d id %h kind %h lvl %0d held %0d,",
                               " got st %0d id %h kind %h lvl %0d held %0d"},
                              want.status, want.id, want.kind, want.level, want.held,
                              got.status, got.id, got.kind, got.level, got.held);
                  fail_count <= fail_count + 1;
               end
               if (want.status == ST_POPPED) pop_hits <= pop_hits + 1;
               if (want.status inside {ST_EMPTY, ST_FULL, ST_BADLVL})
                  error_hits <= error_hits + 1;
            end
         end
      end
      pending_count <= answers_due.size();
   end
endmodule

// ===== verif/tb_weighted_lottery_job_queue.sv =====
`timescale 1ns / 1ps

// Top of the job queue testbench. It resets the block, offers request
// beats with random gaps, takes response beats with random stalls, and
// leaves all prediction and comparison to the scoreboard instance.
module tb_weighted_lottery_job_queue;
   import wljq_pkg::*;

   // A pop walks the levels twice and runs a 16-step remainder; the idle
   // limit covers that plus the long receiver hold-off with room to spare.
   localparam int IDLE_LIMIT  = 5000;
   localparam int RANDOM_JOBS = 1950;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = ACT_PUSH;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int  fail_count, pending_count, pop_hits, error_hits;
   int  idle_cycles = 0;
   int  beats_sent  = 0;
   int  rsp_wait    = 0;
   bit  hold_off     = 1'b0;
   bit  quiet_phase  = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   weighted_lottery_job_queue uut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   wljq_scoreboard scoreboard (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .pending_count, .pop_hits, .error_hits
   );

   // Sends one request beat and waits until the block takes it. The beat is
   // preceded by a random gap unless the quiet phase asks for back-to-back.
   // tvalid stays high across back-to-back beats and drops only for a gap.
   task automatic send_job(logic act, logic [ID_W-1:0] id, logic [KIND_W-1:0] kind,
                           logic [LVL_W-1:0] lvl, logic [RND_W-1:0] draw);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'd0, draw, lvl, kind, id};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   // Random pushes mostly land on valid levels, with the odd bad level.
   task automatic random_push();
      logic [LVL_W-1:0] lvl;
      lvl = ($urandom_range(0, 19) == 0) ? LVL_W'($urandom_range(9, 15)) :
            ($urandom_range(0, 29) == 0) ? '0 : LVL_W'($urandom_range(1, 8));
      send_job(ACT_PUSH, $urandom, KIND_W'($urandom), lvl, RND_W'($urandom));
   endtask

   // Receiver: after each response beat it draws how many cycles to wait
   // before it is ready again; one long hold-off lets the block fill its
   // output register and block its input.
   always @(posedge clock) begin
      int wait_draw;
      if (reset || hold_off) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         wait_draw  = quiet_phase ? 0 : $urandom_range(0, 17);
         rsp_wait   <= wait_draw;
         rsp_tready <= (wait_draw == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", pending_count);
         $display("** weighted_lottery_job_queue: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty pop, bad levels, extreme fields, one level
      // filled to the brim then overfilled, pops with extreme draws.
      send_job(ACT_POP, '1, '1, 4'd3, 16'h0000);
      send_job(ACT_PUSH, '0, '0, 4'd0, '1);
      send_job(ACT_PUSH, '1, '1, 4'd9, '0);
      send_job(ACT_PUSH, '1, '1, 4'd15, '1);
      send_job(ACT_PUSH, 32'hFFFF_FFFF, 8'hFF, 4'd1, 16'h0);
      send_job(ACT_PUSH, 32'h0, 8'h00, 4'd8, 16'hFFFF);
      for (int i = 0; i < 16; i++)
         send_job(ACT_PUSH, 32'hA5A5_0000 + 32'(i), 8'(i), 4'd8, '0);
      send_job(ACT_POP, '0, '0, 4'd0, 16'hFFFF);
      send_job(ACT_POP, '1, '1, 4'd15, 16'h0000);
      send_job(ACT_POP, '0, '0, 4'd0, 16'h8000);

      // Long hold-off: the receiver stops while requests keep coming.
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (6) random_push();
      join

      // Random part in bursts: fill phases, drain phases and mixed ones so
      // the queue swings between empty and several full levels.
      while (beats_sent < RANDOM_JOBS) begin
         int mode;
         mode = $urandom_range(0, 3);
         quiet_phase = ($urandom_range(0, 5) == 0);
         repeat ($urandom_range(10, 60)) begin
            int push_odds;
            push_odds = (mode == 0) ? 90 : (mode == 1) ? 15 : 50;
            if ($urandom_range(0, 99) < push_odds)
               random_push();
            else
               send_job(ACT_POP, $urandom, KIND_W'($urandom), LVL_W'($urandom),
                        RND_W'($urandom));
         end
         quiet_phase = 1'b0;
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display({"Sent %0d request beats; %0d pops returned a job and %0d beats ",
                "ended in an error status."}, beats_sent, pop_hits, error_hits);
      if (fail_count == 0)
         $display("** weighted_lottery_job_queue: PASSED **");
      else
         $display("** weighted_lottery_job_queue: FAILED **");
      $finish;
   end
endmodule

// ===== weighted_lottery_job_queue.f =====
rtl/core/wljq_pkg.sv
rtl/core/wljq_ram.sv
rtl/core/weighted_lottery_job_queue.sv
rtl/core/wljq_checker.sv
verif/wljq_checker.sv
verif/tb_weighted_lottery_job_queue.sv
